>>> rtl/wdof_pkg.sv
// ----------------------------------------------------------------------------
// wdof_pkg
// shared defaults for the window deviation outlier flag block
// ----------------------------------------------------------------------------
package wdof_pkg;

  // default window length and sample width
  localparam int DEF_WINDOW      = 64;
  localparam int DEF_SAMPLE_BITS = 24;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH     = 4;

endpackage

>>> rtl/wdof_ram.sv
// ----------------------------------------------------------------------------
// wdof_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module wdof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/wdof_queue.sv
// ----------------------------------------------------------------------------
// wdof_queue
// short register queue that decouples the front from the back
// ----------------------------------------------------------------------------
module wdof_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic [PW-1:0]    wr_ptr_next;
  logic [PW-1:0]    rd_ptr_next;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = store[rd_ptr];

  // pointer wrap
  assign wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // checks
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH)) else $error("queue count out of range");

endmodule

>>> rtl/wdof_front.sv
// ----------------------------------------------------------------------------
// wdof_front
// takes samples, keeps the window ring and running sum, queues each transaction
// ----------------------------------------------------------------------------
module wdof_front #(
  parameter int WINDOW      = wdof_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = wdof_pkg::DEF_SAMPLE_BITS,
  localparam int LW = $clog2(WINDOW),
  localparam int SW = SAMPLE_BITS + LW,
  localparam int EW = 2 * SAMPLE_BITS + SW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [EW-1:0]          q_data
);

  import wdof_pkg::*;

  logic                          accept;
  logic [LW-1:0]                 slot;
  logic [LW-1:0]                 slot_next;
  logic                          wrapped;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          sum_next;
  logic [SAMPLE_BITS-1:0]        ram_rd;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic signed [SAMPLE_BITS-1:0] x;

  assign accept = push && !q_full;
  assign x      = sample;

  // ring slot advance
  assign slot_next = (slot == LW'(WINDOW - 1)) ? '0 : slot + 1'b1;

  // ring store, the entry for the next slot is read ahead
  wdof_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (sample),
    .re    (accept),
    .raddr (slot_next),
    .rdata (ram_rd)
  );

  // entries not yet written since reset read as zero
  assign oldest   = wrapped ? ram_rd : '0;
  assign sum_next = sum - SW'(oldest) + SW'(x);

  // transaction to the back: sample, evicted entry, sum before this sample
  assign q_push = accept;
  assign q_data = {sample, oldest, sum};

  // ring position and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
      sum     <= '0;
    end else if (accept) begin
      slot <= slot_next;
      sum  <= sum_next;
      if (slot == LW'(WINDOW - 1)) begin
        wrapped <= 1'b1;
      end
    end
  end

  // checks
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= LW'(WINDOW - 1)) else $error("ring slot out of range");
  a_wrapped_holds: assert property (@(posedge clk) disable iff (rst)
    wrapped |=> wrapped) else $error("wrap flag cleared without reset");
  a_fresh_sum: assert property (@(posedge clk) disable iff (rst)
    (!wrapped && slot == '0) |-> sum == '0) else $error("sum non-zero on fresh ring");

endmodule

>>> rtl/wdof_back.sv
// ----------------------------------------------------------------------------
// wdof_back
// pipelined deviation test with running square sum and result register
// ----------------------------------------------------------------------------
module wdof_back #(
  parameter int WINDOW      = wdof_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = wdof_pkg::DEF_SAMPLE_BITS,
  localparam int SB = SAMPLE_BITS,
  localparam int LW = $clog2(WINDOW),
  localparam int SW = SB + LW,
  localparam int EW = 2 * SB + SW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  logic [EW-1:0] q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic          significant
);

  import wdof_pkg::*;

  localparam int DW = SW + 1;
  localparam int QW = 2 * SB - 1 + LW;
  localparam int RW = QW + LW;
  localparam int CW = 2 * DW + 1;
  localparam int DK = (DW + 1) / 2;
  localparam int DH = DW - DK;
  localparam int SK = (SW + 1) / 2;
  localparam int SH = SW - SK;

  localparam logic signed [DW-1:0] WIN_D = DW'(WINDOW);
  localparam logic [RW-1:0]        WIN_Q = RW'(WINDOW);

  logic en;

  // head of queue
  logic signed [SB-1:0] hx;
  logic signed [SB-1:0] ho;
  logic signed [SW-1:0] hs;
  logic signed [DW-1:0] dev;
  logic [DW-1:0]        dev_mag_c;
  logic [SW-1:0]        s_mag_c;
  logic [SB-1:0]        x_mag;
  logic [SB-1:0]        o_mag;

  // stage 1
  logic                 st1_valid;
  logic [DW-1:0]        st1_dev;
  logic [SW-1:0]        st1_s;
  logic [2*SB-1:0]      st1_xsq;
  logic [2*SB-1:0]      st1_osq;
  logic [QW-1:0]        qsum;
  logic [DH-1:0]        dh;
  logic [DK-1:0]        dl;
  logic [SH-1:0]        sh;
  logic [SK-1:0]        sl;

  // stage 2
  logic                 st2_valid;
  logic [2*DH-1:0]      st2_dhh;
  logic [DH+DK-1:0]     st2_dhl;
  logic [2*DK-1:0]      st2_dll;
  logic [2*SH-1:0]      st2_shh;
  logic [SH+SK-1:0]     st2_shl;
  logic [2*SK-1:0]      st2_sll;
  logic [RW-1:0]        st2_wq;

  // stage 3
  logic                 st3_valid;
  logic [2*DW-1:0]      st3_dsq;
  logic [2*SW-1:0]      st3_ssq;
  logic [RW-1:0]        st3_wq;
  logic [CW-1:0]        lhs;

  // result register
  logic                 out_valid;

  // whole pipeline moves unless a result is waiting and not taken
  assign en    = !out_valid || pop;
  assign q_pop = en && q_valid;
  assign empty = !out_valid;

  // unpack the queued transaction
  assign hx = q_data[EW-1 -: SB];
  assign ho = q_data[SW+SB-1 -: SB];
  assign hs = q_data[SW-1:0];

  // deviation from the scaled mean, and magnitudes for squaring
  assign dev       = DW'(hx) * WIN_D - DW'(hs);
  assign dev_mag_c = dev[DW-1] ? DW'(-dev) : DW'(dev);
  assign s_mag_c   = hs[SW-1] ? SW'(-hs) : SW'(hs);
  assign x_mag     = hx[SB-1] ? SB'(-hx) : SB'(hx);
  assign o_mag     = ho[SB-1] ? SB'(-ho) : SB'(ho);

  // split the wide magnitudes into halves for partial products
  assign dh = st1_dev[DW-1:DK];
  assign dl = st1_dev[DK-1:0];
  assign sh = st1_s[SW-1:SK];
  assign sl = st1_s[SK-1:0];

  // stage registers, payload only
  always_ff @(posedge clk) begin
    if (en) begin
      st1_dev <= dev_mag_c;
      st1_s   <= s_mag_c;
      st1_xsq <= (2*SB)'(x_mag) * (2*SB)'(x_mag);
      st1_osq <= (2*SB)'(o_mag) * (2*SB)'(o_mag);

      st2_dhh <= (2*DH)'(dh) * (2*DH)'(dh);
      st2_dhl <= (DH+DK)'(dh) * (DH+DK)'(dl);
      st2_dll <= (2*DK)'(dl) * (2*DK)'(dl);
      st2_shh <= (2*SH)'(sh) * (2*SH)'(sh);
      st2_shl <= (SH+SK)'(sh) * (SH+SK)'(sl);
      st2_sll <= (2*SK)'(sl) * (2*SK)'(sl);
      st2_wq  <= RW'(qsum) * WIN_Q;

      st3_dsq <= ((2*DW)'(st2_dhh) << (2*DK)) + ((2*DW)'(st2_dhl) << (DK+1))
               + (2*DW)'(st2_dll);
      st3_ssq <= ((2*SW)'(st2_shh) << (2*SK)) + ((2*SW)'(st2_shl) << (SK+1))
               + (2*SW)'(st2_sll);
      st3_wq  <= st2_wq;

      significant <= (lhs >= CW'(st3_wq));
    end
  end

  // final compare operand
  assign lhs = CW'(st3_dsq) + CW'(st3_ssq);

  // valid bits and running square sum
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
      out_valid <= 1'b0;
      qsum      <= '0;
    end else if (en) begin
      st1_valid <= q_valid;
      st2_valid <= st1_valid;
      st3_valid <= st2_valid;
      out_valid <= st3_valid;
      // square sum moves on as the transaction leaves stage 1
      if (st1_valid) begin
        qsum <= qsum + QW'(st1_xsq) - QW'(st1_osq);
      end
    end
  end

  // checks
  a_qsum_hold: assert property (@(posedge clk) disable iff (rst)
    !(en && st1_valid) |=> $stable(qsum)) else $error("square sum moved without transaction");
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (en && st1_valid) |=> st2_valid) else $error("transaction lost in pipeline");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    (en && !st3_valid) |=> !out_valid) else $error("result without transaction");

endmodule

>>> rtl/window_deviation_outlier_flag_core.sv
// ----------------------------------------------------------------------------
// window_deviation_outlier_flag_core
// flags samples lying at least one standard deviation from the window mean
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  sample in | push / full        | sample (SAMPLE_BITS, signed)
//  result    | pop / empty        | significant (1 bit)
//
//  one transaction per cycle sustained unless full or a waiting result stalls it;
//  the front takes a sample every cycle because the ring entry it evicts is read
//  one sample ahead from the ring ram; each sample passes the queue, stages 1 to 3
//  and the result register; the queue between front and back holds four transactions while pop is low
//  synchronous reset empties the pipeline; ring entries not yet written since
//  reset count as zero through a wrap flag, so no clearing pass is needed
// ----------------------------------------------------------------------------
module window_deviation_outlier_flag_core #(
  parameter int WINDOW      = wdof_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = wdof_pkg::DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   pop,
  output logic                   empty,
  output logic                   significant
);

  import wdof_pkg::*;

  localparam int LW = $clog2(WINDOW);
  localparam int SW = SAMPLE_BITS + LW;
  localparam int EW = 2 * SAMPLE_BITS + SW;

  logic          q_push;
  logic [EW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic [EW-1:0] q_rdata;
  logic          q_empty;

  assign full = q_full;

  // front: ring store and running sum
  wdof_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .sample (sample),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // decoupling queue
  wdof_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: deviation test and result register
  wdof_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .significant (significant)
  );

endmodule
